// ===== hdl/mcsp_pkg.sv =====
// shared types, widths and reset constants for the metronome click player
package mcsp_pkg;

  // field and register widths
  localparam int MODE_W        = 2;
  localparam int INDEX_W       = 12;
  localparam int SAMPLE_W      = 16;
  localparam int INTERVAL_W    = 24;
  localparam int VOLUME_W      = 16;
  localparam int SOUND_LEN_W   = 13;
  localparam int SCHED_LEN_W   = 9;
  localparam int FRAME_W       = 48;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 24;

  // default table depths
  localparam int SOUND_DEPTH_DEFAULT    = 4096;
  localparam int SCHEDULE_DEPTH_DEFAULT = 256;

  // default tempo: 48 kHz frames at 130 beats per minute
  localparam int SAMPLE_RATE      = 48000;
  localparam int SECONDS_PER_MIN  = 60;
  localparam int DEFAULT_BPM      = 130;

  localparam logic [INTERVAL_W-1:0] CLICK_INTERVAL_RESET =
    INTERVAL_W'(SAMPLE_RATE * SECONDS_PER_MIN / DEFAULT_BPM);
  localparam logic [VOLUME_W-1:0]    VOLUME_RESET       = 16'h8000;
  localparam logic [SOUND_LEN_W-1:0] SOUND_LEN_RESET    = 13'd1;
  localparam logic [SCHED_LEN_W-1:0] SCHED_LEN_RESET    = 9'd0;

  // sample of sound entry zero until it is written
  localparam logic [SAMPLE_W-1:0] SAMPLE_FULL_SCALE = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN        = 16'h8000;

  // input word kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK        = 2'd0,
    MODE_WRITE_SOUND = 2'd1,
    MODE_WRITE_SCHED = 2'd2,
    MODE_START       = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLICK_INTERVAL  = 2'd0,
    CFG_VOLUME          = 2'd1,
    CFG_SOUND_LENGTH    = 2'd2,
    CFG_SCHEDULE_LENGTH = 2'd3
  } cfg_index_t;

endpackage

// ===== hdl/mcsp_ram.sv =====
// single write port, single registered read port memory
module mcsp_ram #(
  parameter int WIDTH = mcsp_pkg::SAMPLE_W,
  parameter int DEPTH = mcsp_pkg::SOUND_DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mcsp_scale.sv =====
// q1.15 volume scaling with floor rounding and 16-bit saturation
module mcsp_scale (
  input  logic signed [mcsp_pkg::SAMPLE_W-1:0] sample,
  input  logic        [mcsp_pkg::VOLUME_W-1:0] volume,
  output logic signed [mcsp_pkg::SAMPLE_W-1:0] scaled
);

  logic signed [32:0] product;
  logic        [17:0] shifted;

  // signed sample times unsigned gain
  assign product = sample * $signed({1'b0, volume});

  // arithmetic shift by 15 rounds toward minus infinity
  assign shifted = product[32:15];

  // clamp to the 16-bit range
  always_comb begin
    if (!shifted[17] && (shifted[16:15] != 2'b00)) begin
      scaled = $signed(mcsp_pkg::SAMPLE_FULL_SCALE);
    end else if (shifted[17] && (shifted[16:15] != 2'b11)) begin
      scaled = $signed(mcsp_pkg::SAMPLE_MIN);
    end else begin
      scaled = $signed(shifted[15:0]);
    end
  end

endmodule

// ===== hdl/metronome_click_sample_player.sv =====
// metronome click generator: input register, click state, tables, result register
// a tick is held in the input register, then its result word is registered in the result register
// throughput: one word per cycle; only a tick waits, and only on a stalled full result register
// tables are read ahead, with addresses from the next state; the longest path is the frame compare,
// the 48-bit next-click add and the read-ahead compare, the 16x17 multiply is a path of its own
// reset: synchronous, clears control state and restores register defaults; sound entry zero
// reads full scale until written, other table entries are undefined, no clearing pass
module metronome_click_sample_player #(
  parameter int SOUND_DEPTH    = mcsp_pkg::SOUND_DEPTH_DEFAULT,
  parameter int SCHEDULE_DEPTH = mcsp_pkg::SCHEDULE_DEPTH_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration
  input  logic                                    config_we,
  input  logic [mcsp_pkg::CFG_INDEX_W-1:0]        config_index,
  input  logic [mcsp_pkg::CFG_DATA_W-1:0]         config_data,
  // input channel
  input  logic                                    item_valid,
  output logic                                    item_stall,
  input  logic [mcsp_pkg::MODE_W-1:0]             mode,
  input  logic [mcsp_pkg::INDEX_W-1:0]            write_index,
  input  logic signed [mcsp_pkg::SAMPLE_W-1:0]    sample_value,
  input  logic [mcsp_pkg::INTERVAL_W-1:0]         interval_value,
  // result channel
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic signed [mcsp_pkg::SAMPLE_W-1:0]    audio_sample,
  output logic                                    click,
  output logic                                    schedule_done
);

  localparam int SND_AW = (SOUND_DEPTH > 1) ? $clog2(SOUND_DEPTH) : 1;
  localparam int SCH_AW = (SCHEDULE_DEPTH > 1) ? $clog2(SCHEDULE_DEPTH) : 1;
  localparam int SND_CW = (SND_AW + 1 > mcsp_pkg::SOUND_LEN_W) ?
                          SND_AW + 1 : mcsp_pkg::SOUND_LEN_W;
  localparam int SCH_CW = (SCH_AW + 1 > mcsp_pkg::SCHED_LEN_W) ?
                          SCH_AW + 1 : mcsp_pkg::SCHED_LEN_W;
  localparam int FW = mcsp_pkg::FRAME_W;
  localparam int IW = mcsp_pkg::INTERVAL_W;
  localparam int QW = mcsp_pkg::SCHED_LEN_W;

  // configuration registers
  logic [IW-1:0]                      click_interval, click_interval_next;
  logic [mcsp_pkg::VOLUME_W-1:0]      volume, volume_next;
  logic [mcsp_pkg::SOUND_LEN_W-1:0]   sound_length, sound_length_next;
  logic [QW-1:0]                      schedule_length, schedule_length_next;

  // input register
  logic                               iq_valid;
  mcsp_pkg::mode_t                    iq_mode;
  logic [mcsp_pkg::INDEX_W-1:0]       iq_index;
  logic [mcsp_pkg::SAMPLE_W-1:0]      iq_sample;
  logic [IW-1:0]                      iq_interval;
  logic                               accept;
  logic                               advance;

  // click state
  logic [FW-1:0]     frame_count, frame_count_next;
  logic [FW-1:0]     next_click_frame, next_click_frame_next;
  logic [SND_AW-1:0] sound_position, sound_position_next;
  logic [QW-1:0]     schedule_position, schedule_position_next;

  // table ports
  logic              snd_we, sch_we;
  logic [SND_AW-1:0] snd_waddr, snd_raddr_next, snd_raddr;
  logic [SCH_AW-1:0] sch_waddr, sch_raddr_next;
  logic [mcsp_pkg::SAMPLE_W-1:0] snd_rdata, snd_byp_data, snd_data;
  logic [IW-1:0]     sch_rdata, sch_byp_data, sch_data;
  logic              snd_byp, sch_byp, snd0_valid;

  // per-tick decisions
  logic [QW-1:0]     qlen_eff;
  logic              click_due, fixed_mode, exhausted;
  logic [IW-1:0]     interval_sel;
  logic              tick_click, tick_done;
  logic signed [mcsp_pkg::SAMPLE_W-1:0] scaled;

  // read-ahead decisions on the next state
  logic              due_ahead;
  logic [SND_AW-1:0] pos_ahead;
  logic [SND_CW-1:0] slm1_ahead, pos_ext;
  logic [QW-1:0]     qlen_ahead;

  // clamp schedule length to the table depth
  function automatic logic [QW-1:0] clamp_sched_len(input logic [QW-1:0] len);
    logic [QW-1:0] res;
    res = len;
    if (SCH_CW'(len) > SCH_CW'(SCHEDULE_DEPTH)) begin
      res = QW'(SCHEDULE_DEPTH);
    end
    return res;
  endfunction

  // clamp sound length to 1..depth, minus one
  function automatic logic [SND_CW-1:0] sound_last(
    input logic [mcsp_pkg::SOUND_LEN_W-1:0] len
  );
    logic [SND_CW-1:0] res;
    res = SND_CW'(len);
    if (res == '0) begin
      res = SND_CW'(1);
    end else if (res > SND_CW'(SOUND_DEPTH)) begin
      res = SND_CW'(SOUND_DEPTH);
    end
    return res - SND_CW'(1);
  endfunction

  // configuration next values
  always_comb begin
    click_interval_next  = click_interval;
    volume_next          = volume;
    sound_length_next    = sound_length;
    schedule_length_next = schedule_length;
    if (config_we) begin
      case (mcsp_pkg::cfg_index_t'(config_index))
        mcsp_pkg::CFG_CLICK_INTERVAL:  click_interval_next  = config_data[IW-1:0];
        mcsp_pkg::CFG_VOLUME:          volume_next          = config_data[15:0];
        mcsp_pkg::CFG_SOUND_LENGTH:    sound_length_next    = config_data[12:0];
        mcsp_pkg::CFG_SCHEDULE_LENGTH: schedule_length_next = config_data[QW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      click_interval  <= mcsp_pkg::CLICK_INTERVAL_RESET;
      volume          <= mcsp_pkg::VOLUME_RESET;
      sound_length    <= mcsp_pkg::SOUND_LEN_RESET;
      schedule_length <= mcsp_pkg::SCHED_LEN_RESET;
    end else begin
      click_interval  <= click_interval_next;
      volume          <= volume_next;
      sound_length    <= sound_length_next;
      schedule_length <= schedule_length_next;
    end
  end

  // handshake: only a tick needs room in the result register
  assign accept     = item_valid && !item_stall;
  assign advance    = iq_valid &&
                      ((iq_mode != mcsp_pkg::MODE_TICK) || !result_valid || !result_stall);
  assign item_stall = iq_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (accept) begin
      iq_valid <= 1'b1;
    end else if (advance) begin
      iq_valid <= 1'b0;
    end
    if (accept) begin
      iq_mode     <= mcsp_pkg::mode_t'(mode);
      iq_index    <= write_index;
      iq_sample   <= sample_value;
      iq_interval <= interval_value;
    end
  end

  // table data with write bypass and entry zero default
  assign snd_data = snd_byp ? snd_byp_data :
                    ((snd_raddr == '0) && !snd0_valid) ? mcsp_pkg::SAMPLE_FULL_SCALE :
                    snd_rdata;
  assign sch_data = sch_byp ? sch_byp_data : sch_rdata;

  // click decision for the word in the input register
  assign qlen_eff     = clamp_sched_len(schedule_length);
  assign click_due    = frame_count >= next_click_frame;
  assign fixed_mode   = qlen_eff == '0;
  assign exhausted    = schedule_position >= qlen_eff;
  assign interval_sel = fixed_mode ? click_interval : sch_data;
  assign tick_click   = click_due;
  assign tick_done    = click_due && !fixed_mode && exhausted;

  // state update
  always_comb begin
    frame_count_next       = frame_count;
    next_click_frame_next  = next_click_frame;
    sound_position_next    = sound_position;
    schedule_position_next = schedule_position;
    snd_we    = 1'b0;
    sch_we    = 1'b0;
    snd_waddr = SND_AW'(iq_index);
    sch_waddr = SCH_AW'(iq_index);
    if (advance) begin
      case (iq_mode)
        mcsp_pkg::MODE_TICK: begin
          if (click_due) begin
            next_click_frame_next = next_click_frame + FW'(interval_sel);
            sound_position_next   = '0;
            if (!fixed_mode && !exhausted) begin
              schedule_position_next = schedule_position + QW'(1);
            end
          end
          if (sound_position_next < SND_AW'(SOUND_DEPTH - 1)) begin
            sound_position_next = sound_position_next + SND_AW'(1);
          end
          frame_count_next = frame_count + FW'(1);
        end
        mcsp_pkg::MODE_WRITE_SOUND: begin
          snd_we = 32'(iq_index) < 32'(SOUND_DEPTH);
        end
        mcsp_pkg::MODE_WRITE_SCHED: begin
          sch_we = 32'(iq_index) < 32'(SCHEDULE_DEPTH);
        end
        mcsp_pkg::MODE_START: begin
          sound_position_next    = '0;
          schedule_position_next = '0;
          next_click_frame_next  = frame_count;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count       <= '0;
      next_click_frame  <= '0;
      sound_position    <= '0;
      schedule_position <= '0;
    end else begin
      frame_count       <= frame_count_next;
      next_click_frame  <= next_click_frame_next;
      sound_position    <= sound_position_next;
      schedule_position <= schedule_position_next;
    end
  end

  // read addresses for the next tick, taken from the next state
  assign due_ahead  = frame_count_next >= next_click_frame_next;
  assign pos_ahead  = due_ahead ? '0 : sound_position_next;
  assign slm1_ahead = sound_last(sound_length_next);
  assign pos_ext    = SND_CW'(pos_ahead);
  assign qlen_ahead = clamp_sched_len(schedule_length_next);

  always_comb begin
    if (rst) begin
      snd_raddr_next = '0;
      sch_raddr_next = '0;
    end else begin
      snd_raddr_next = (pos_ext > slm1_ahead) ? SND_AW'(slm1_ahead) : pos_ahead;
      sch_raddr_next = (schedule_position_next >= qlen_ahead) ?
                       SCH_AW'(qlen_ahead - QW'(1)) : SCH_AW'(schedule_position_next);
    end
  end

  // read address and bypass registers
  always_ff @(posedge clk) begin
    if (rst) begin
      snd_byp    <= 1'b0;
      sch_byp    <= 1'b0;
      snd0_valid <= 1'b0;
    end else begin
      snd_byp <= snd_we && (snd_waddr == snd_raddr_next);
      sch_byp <= sch_we && (sch_waddr == sch_raddr_next);
      if (snd_we && (snd_waddr == '0)) begin
        snd0_valid <= 1'b1;
      end
    end
    snd_raddr    <= snd_raddr_next;
    snd_byp_data <= iq_sample;
    sch_byp_data <= iq_interval;
  end

  mcsp_ram #(
    .WIDTH (mcsp_pkg::SAMPLE_W),
    .DEPTH (SOUND_DEPTH)
  ) u_sound_ram (
    .clk   (clk),
    .we    (snd_we),
    .waddr (snd_waddr),
    .wdata (iq_sample),
    .raddr (snd_raddr_next),
    .rdata (snd_rdata)
  );

  mcsp_ram #(
    .WIDTH (IW),
    .DEPTH (SCHEDULE_DEPTH)
  ) u_schedule_ram (
    .clk   (clk),
    .we    (sch_we),
    .waddr (sch_waddr),
    .wdata (iq_interval),
    .raddr (sch_raddr_next),
    .rdata (sch_rdata)
  );

  mcsp_scale u_scale (
    .sample (signed'(snd_data)),
    .volume (volume),
    .scaled (scaled)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && (iq_mode == mcsp_pkg::MODE_TICK)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance && (iq_mode == mcsp_pkg::MODE_TICK)) begin
      audio_sample  <= scaled;
      click         <= tick_click;
      schedule_done <= tick_done;
    end
  end

  // a done flag only comes with a click
  a_done_with_click: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!schedule_done || click))
    else $error("schedule_done without click");

  // upstream only waits on a tick blocked by a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (iq_valid && (iq_mode == mcsp_pkg::MODE_TICK) &&
                    result_valid && result_stall))
    else $error("input stalled without cause");

  // a start arms a click for the next tick
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (advance && (iq_mode == mcsp_pkg::MODE_START)) |=> click_due)
    else $error("start did not arm a click");

  // sound position stays within the table
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    sound_position <= SND_AW'(SOUND_DEPTH - 1))
    else $error("sound position out of range");

endmodule
